/* design/ksc_pkg.sv */
`default_nettype none

package ksc_pkg;

  localparam int unsigned TicksPerSecond = 10;
  localparam int unsigned TickW = (TicksPerSecond > 1) ? $clog2(TicksPerSecond) : 1;
  localparam logic [TickW-1:0] TickLast = TickW'(TicksPerSecond - 1);

  localparam logic [1:0] EvTick  = 2'd0;
  localparam logic [1:0] EvKey   = 2'd1;
  localparam logic [1:0] EvPulse = 2'd2;

  localparam logic [3:0] KeyNext     = 4'd15;
  localparam logic [3:0] KeyDigitEnd = 4'd10;

  localparam logic [2:0] SetRun     = 3'd0;
  localparam logic [2:0] SetHours   = 3'd1;
  localparam logic [2:0] SetMinutes = 3'd2;
  localparam logic [2:0] SetSeconds = 3'd3;
  localparam logic [2:0] SetLimit   = 3'd4;

  localparam logic [6:0] HourWrap   = 7'd13;
  localparam logic [6:0] MinSecWrap = 7'd60;
  localparam logic [6:0] DigitScale = 7'd10;
  localparam logic [5:0] MinSecLast = 6'd59;
  localparam logic [3:0] HourLast   = 4'd12;
  localparam logic [3:0] HourFirst  = 4'd1;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic [3:0] key_code;
  } ksc_item_t;

  typedef struct packed {
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] product_limit;
    logic [6:0] product_count;
    logic [2:0] setting_mode;
  } ksc_result_t;

endpackage

`default_nettype wire

/* design/ksc_if.sv */
`default_nettype none

interface ksc_item_if import ksc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] key_code;

  modport source (output valid, output mode, output key_code, input ready);
  modport sink   (input valid, input mode, input key_code, output ready);
endinterface

interface ksc_result_if import ksc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [3:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [6:0] product_limit;
  logic [6:0] product_count;
  logic [2:0] setting_mode;

  modport source (output valid, output hours, output minutes, output seconds,
                  output product_limit, output product_count, output setting_mode,
                  input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input product_limit, input product_count, input setting_mode,
                  output ready);
endinterface

`default_nettype wire

/* design/keypad_set_clock_with_counter_core.sv */
// Twelve-hour clock with keypad setting and product counter. Each input item is
// one event: a tenth-second tick, a key press or a product pulse; each gives one
// result item with the clock, limit, count and setting mode after the event.
// An item is registered, updates the state and lands in the result register,
// so the block takes one item per cycle while the result register is free;
// only a stalled result register holds the input side.
`default_nettype none

module keypad_set_clock_with_counter_core import ksc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ksc_item_if.sink     in_i,
  ksc_result_if.source out_o
);

  ksc_item_t   item;
  ksc_result_t res;
  logic        free;
  logic        adv;

  assign adv = item.valid && free;

  ksc_in_reg u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .item_o (item)
  );

  ksc_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .adv_i  (adv),
    .res_o  (res)
  );

  ksc_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

/* design/ksc_in_reg.sv */
`default_nettype none

module ksc_in_reg import ksc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ksc_item_if.sink    in_i,
  input  wire logic   adv_i,
  output ksc_item_t   item_o
);

  logic       valid_q, valid_d;
  logic [1:0] mode_q;
  logic [3:0] key_q;
  logic       take;

  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q <= in_i.mode;
      key_q  <= in_i.key_code;
    end
  end

  assign item_o.valid    = valid_q;
  assign item_o.mode     = mode_q;
  assign item_o.key_code = key_q;

endmodule

`default_nettype wire

/* design/ksc_update.sv */
`default_nettype none

module ksc_update import ksc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ksc_item_t item_i,
  input  wire logic  adv_i,
  output ksc_result_t res_o
);

  logic [TickW-1:0] sub_q, sub_d;
  logic [2:0]       set_mode_q, set_mode_d;
  logic             digit_q, digit_d;
  logic [6:0]       entry_q, entry_d;
  logic [3:0]       hour_q, hour_d;
  logic [5:0]       minute_q, minute_d;
  logic [5:0]       second_q, second_d;
  logic [6:0]       limit_q, limit_d;
  logic [6:0]       count_q, count_d;
  logic [6:0]       count_pre;
  logic [6:0]       key_w;
  logic [6:0]       key_tens;

  assign key_w    = {3'b000, item_i.key_code};
  assign key_tens = 7'(key_w * DigitScale);

  always_comb begin
    sub_d      = sub_q;
    set_mode_d = set_mode_q;
    digit_d    = digit_q;
    entry_d    = entry_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    second_d   = second_q;
    limit_d    = limit_q;
    count_pre  = count_q;
    case (item_i.mode)
      EvTick: begin
        if (sub_q >= TickLast) begin
          sub_d = '0;
          if (second_q >= MinSecLast) begin
            second_d = '0;
            if (minute_q >= MinSecLast) begin
              minute_d = '0;
              hour_d   = (hour_q >= HourLast) ? HourFirst : hour_q + 4'd1;
            end else begin
              minute_d = minute_q + 6'd1;
            end
          end else begin
            second_d = second_q + 6'd1;
          end
        end else begin
          sub_d = sub_q + TickW'(1);
        end
      end
      EvKey: begin
        if (item_i.key_code == KeyNext) begin
          digit_d    = 1'b0;
          set_mode_d = (set_mode_q >= SetLimit) ? SetRun : set_mode_q + 3'd1;
        end else if (item_i.key_code < KeyDigitEnd) begin
          if (!digit_q) begin
            entry_d = key_tens;
            if (set_mode_q == SetLimit) begin
              limit_d = key_tens;
            end
          end else begin
            entry_d = entry_q + key_w;
            if (set_mode_q == SetLimit) begin
              limit_d = limit_q + key_w;
            end
          end
          digit_d = !digit_q;
          case (set_mode_q)
            SetHours: begin
              if (entry_d >= HourWrap) begin
                hour_d  = HourFirst;
                digit_d = 1'b0;
              end else begin
                hour_d = entry_d[3:0];
              end
            end
            SetMinutes: begin
              if (entry_d >= MinSecWrap) begin
                minute_d = '0;
                digit_d  = 1'b0;
              end else begin
                minute_d = entry_d[5:0];
              end
            end
            SetSeconds: begin
              if (entry_d >= MinSecWrap) begin
                second_d = '0;
                digit_d  = 1'b0;
              end else begin
                second_d = entry_d[5:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      EvPulse: begin
        count_pre = count_q + 7'd1;
      end
      default: begin
      end
    endcase
    count_d = (count_pre > limit_d) ? 7'd1 : count_pre;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q      <= '0;
      set_mode_q <= SetRun;
      digit_q    <= 1'b0;
      entry_q    <= '0;
      hour_q     <= '0;
      minute_q   <= '0;
      second_q   <= '0;
      limit_q    <= '0;
      count_q    <= '0;
    end else if (adv_i) begin
      sub_q      <= sub_d;
      set_mode_q <= set_mode_d;
      digit_q    <= digit_d;
      entry_q    <= entry_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
      limit_q    <= limit_d;
      count_q    <= count_d;
    end
  end

  assign res_o.hours         = hour_d;
  assign res_o.minutes       = minute_d;
  assign res_o.seconds       = second_d;
  assign res_o.product_limit = limit_d;
  assign res_o.product_count = count_d;
  assign res_o.setting_mode  = set_mode_d;

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable({sub_q, set_mode_q, digit_q, entry_q, hour_q,
                        minute_q, second_q, limit_q, count_q}))
    else $error("state moved without an item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= limit_q || count_q == 7'd1)
    else $error("product count above limit");

  a_second_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.mode == EvTick && sub_q == TickLast
    |=> sub_q == '0 && second_q != $past(second_q))
    else $error("second did not advance on tick wrap");

  a_next_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.mode == EvKey && item_i.key_code == KeyNext
    |=> !digit_q && set_mode_q != $past(set_mode_q))
    else $error("setting mode key did not step");

endmodule

`default_nettype wire

/* design/ksc_out_reg.sv */
`default_nettype none

module ksc_out_reg import ksc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    adv_i,
  input  wire ksc_result_t res_i,
  output logic         free_o,
  ksc_result_if.source out_o
);

  logic        valid_q, valid_d;
  ksc_result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = adv_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.hours         = res_q.hours;
  assign out_o.minutes       = res_q.minutes;
  assign out_o.seconds       = res_q.seconds;
  assign out_o.product_limit = res_q.product_limit;
  assign out_o.product_count = res_q.product_count;
  assign out_o.setting_mode  = res_q.setting_mode;

endmodule

`default_nettype wire
